[rtl/core/tvg_pkg.sv]
// Shared types, widths and the CORDIC angle table of the torus vertex generator.
`timescale 1ns / 1ps
`default_nettype none

package tvg_pkg;

    localparam int IDX_W        = 10;
    localparam int SEG_W        = 11;
    localparam int RAD_W        = 16;
    localparam int CORDIC_STEPS = 30;
    localparam int CW           = 33;
    localparam int TRIG_W       = 32;
    localparam int PHASE_W      = 32;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;

    typedef enum logic [1:0] {
        REG_MAJOR = 2'd0,
        REG_MINOR = 2'd1,
        REG_RING  = 2'd2,
        REG_TUBE  = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic valid;
        logic err;
    } ctl_t;

    // Rotation angle of each CORDIC step, in units of 2^-32 turn.
    function automatic logic [31:0] atan_turn(input int step);
        logic [31:0] a;
        case (step)
            0:       a = 32'h20000000;
            1:       a = 32'h12E4051E;
            2:       a = 32'h09FB385B;
            3:       a = 32'h051111D4;
            4:       a = 32'h028B0D43;
            5:       a = 32'h0145D7E1;
            6:       a = 32'h00A2F61E;
            7:       a = 32'h00517C55;
            8:       a = 32'h0028BE53;
            9:       a = 32'h00145F2F;
            10:      a = 32'h000A2F98;
            11:      a = 32'h000517CC;
            12:      a = 32'h00028BE6;
            13:      a = 32'h000145F3;
            14:      a = 32'h0000A2F9;
            15:      a = 32'h0000517C;
            16:      a = 32'h000028BE;
            17:      a = 32'h0000145F;
            18:      a = 32'h00000A2F;
            19:      a = 32'h00000517;
            20:      a = 32'h0000028B;
            21:      a = 32'h00000145;
            22:      a = 32'h000000A2;
            23:      a = 32'h00000051;
            24:      a = 32'h00000028;
            25:      a = 32'h00000014;
            26:      a = 32'h0000000A;
            27:      a = 32'h00000005;
            28:      a = 32'h00000002;
            29:      a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

[rtl/core/tvg_div_cell.sv]
// One restoring division step for the ring and tube phase lanes.
`timescale 1ns / 1ps
`default_nettype none

module tvg_div_cell #(
    parameter int NUM_W = 27,
    parameter int Q_W   = 16,
    parameter int BIT   = 26
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire tvg_pkg::ctl_t              ctl_in,
    input  wire logic [tvg_pkg::SEG_W-1:0]  seg_a,
    input  wire logic [tvg_pkg::SEG_W-1:0]  seg_b,
    input  wire logic [NUM_W-1:0]           num_a_in,
    input  wire logic [NUM_W-1:0]           num_b_in,
    input  wire logic [tvg_pkg::SEG_W-1:0]  rem_a_in,
    input  wire logic [tvg_pkg::SEG_W-1:0]  rem_b_in,
    input  wire logic [Q_W-1:0]             q_a_in,
    input  wire logic [Q_W-1:0]             q_b_in,
    output tvg_pkg::ctl_t                   ctl_out,
    output logic [NUM_W-1:0]                num_a_out,
    output logic [NUM_W-1:0]                num_b_out,
    output logic [tvg_pkg::SEG_W-1:0]       rem_a_out,
    output logic [tvg_pkg::SEG_W-1:0]       rem_b_out,
    output logic [Q_W-1:0]                  q_a_out,
    output logic [Q_W-1:0]                  q_b_out
);
    import tvg_pkg::*;

    logic [SEG_W:0]   trial_a;
    logic [SEG_W:0]   trial_b;
    logic             ge_a;
    logic             ge_b;
    logic [SEG_W-1:0] rem_a_next;
    logic [SEG_W-1:0] rem_b_next;

    ctl_t             ctl_reg;
    logic [NUM_W-1:0] num_a_reg;
    logic [NUM_W-1:0] num_b_reg;
    logic [SEG_W-1:0] rem_a_reg;
    logic [SEG_W-1:0] rem_b_reg;
    logic [Q_W-1:0]   q_a_reg;
    logic [Q_W-1:0]   q_b_reg;

    always_comb
    begin
        trial_a    = {rem_a_in, num_a_in[BIT]};
        trial_b    = {rem_b_in, num_b_in[BIT]};
        ge_a       = trial_a >= {1'b0, seg_a};
        ge_b       = trial_b >= {1'b0, seg_b};
        rem_a_next = ge_a ? SEG_W'(trial_a - {1'b0, seg_a}) : trial_a[SEG_W-1:0];
        rem_b_next = ge_b ? SEG_W'(trial_b - {1'b0, seg_b}) : trial_b[SEG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_a_reg <= num_a_in;
            num_b_reg <= num_b_in;
            rem_a_reg <= rem_a_next;
            rem_b_reg <= rem_b_next;
            q_a_reg   <= {q_a_in[Q_W-2:0], ge_a};
            q_b_reg   <= {q_b_in[Q_W-2:0], ge_b};
        end
    end

    assign ctl_out   = ctl_reg;
    assign num_a_out = num_a_reg;
    assign num_b_out = num_b_reg;
    assign rem_a_out = rem_a_reg;
    assign rem_b_out = rem_b_reg;
    assign q_a_out   = q_a_reg;
    assign q_b_out   = q_b_reg;

endmodule

`default_nettype wire

[rtl/core/tvg_cordic_cell.sv]
// One CORDIC rotation step for the ring and tube angle lanes.
`timescale 1ns / 1ps
`default_nettype none

module tvg_cordic_cell #(
    parameter int STEP = 0
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         en,
    input  wire tvg_pkg::ctl_t                ctl_in,
    input  wire logic [1:0]                   quad_a_in,
    input  wire logic [1:0]                   quad_b_in,
    input  wire logic signed [tvg_pkg::CW-1:0] xa_in,
    input  wire logic signed [tvg_pkg::CW-1:0] ya_in,
    input  wire logic signed [tvg_pkg::CW-1:0] za_in,
    input  wire logic signed [tvg_pkg::CW-1:0] xb_in,
    input  wire logic signed [tvg_pkg::CW-1:0] yb_in,
    input  wire logic signed [tvg_pkg::CW-1:0] zb_in,
    output tvg_pkg::ctl_t                     ctl_out,
    output logic [1:0]                        quad_a_out,
    output logic [1:0]                        quad_b_out,
    output logic signed [tvg_pkg::CW-1:0]     xa_out,
    output logic signed [tvg_pkg::CW-1:0]     ya_out,
    output logic signed [tvg_pkg::CW-1:0]     za_out,
    output logic signed [tvg_pkg::CW-1:0]     xb_out,
    output logic signed [tvg_pkg::CW-1:0]     yb_out,
    output logic signed [tvg_pkg::CW-1:0]     zb_out
);
    import tvg_pkg::*;

    localparam logic [31:0]          ANG_U = atan_turn(STEP);
    localparam logic signed [CW-1:0] ANG   = $signed({{(CW-32){1'b0}}, ANG_U});

    logic signed [CW-1:0] xa_next, ya_next, za_next;
    logic signed [CW-1:0] xb_next, yb_next, zb_next;

    ctl_t                 ctl_reg;
    logic [1:0]           quad_a_reg, quad_b_reg;
    logic signed [CW-1:0] xa_reg, ya_reg, za_reg;
    logic signed [CW-1:0] xb_reg, yb_reg, zb_reg;

    always_comb
    begin
        if (!za_in[CW-1])
        begin
            xa_next = xa_in - (ya_in >>> STEP);
            ya_next = ya_in + (xa_in >>> STEP);
            za_next = za_in - ANG;
        end
        else
        begin
            xa_next = xa_in + (ya_in >>> STEP);
            ya_next = ya_in - (xa_in >>> STEP);
            za_next = za_in + ANG;
        end
        if (!zb_in[CW-1])
        begin
            xb_next = xb_in - (yb_in >>> STEP);
            yb_next = yb_in + (xb_in >>> STEP);
            zb_next = zb_in - ANG;
        end
        else
        begin
            xb_next = xb_in + (yb_in >>> STEP);
            yb_next = yb_in - (xb_in >>> STEP);
            zb_next = zb_in + ANG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quad_a_reg <= quad_a_in;
            quad_b_reg <= quad_b_in;
            xa_reg     <= xa_next;
            ya_reg     <= ya_next;
            za_reg     <= za_next;
            xb_reg     <= xb_next;
            yb_reg     <= yb_next;
            zb_reg     <= zb_next;
        end
    end

    assign ctl_out    = ctl_reg;
    assign quad_a_out = quad_a_reg;
    assign quad_b_out = quad_b_reg;
    assign xa_out     = xa_reg;
    assign ya_out     = ya_reg;
    assign za_out     = za_reg;
    assign xb_out     = xb_reg;
    assign yb_out     = yb_reg;
    assign zb_out     = zb_reg;

endmodule

`default_nettype wire

[rtl/core/tvg_mix.sv]
// Quadrant mapping, radius scaling, products and rounding of the vertex coordinates.
`timescale 1ns / 1ps
`default_nettype none

module tvg_mix (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire tvg_pkg::ctl_t                 ctl_in,
    input  wire logic [1:0]                    quad_a,
    input  wire logic [1:0]                    quad_b,
    input  wire logic signed [tvg_pkg::CW-1:0] xa,
    input  wire logic signed [tvg_pkg::CW-1:0] ya,
    input  wire logic signed [tvg_pkg::CW-1:0] xb,
    input  wire logic signed [tvg_pkg::CW-1:0] yb,
    input  wire logic [tvg_pkg::RAD_W-1:0]     major,
    input  wire logic [tvg_pkg::RAD_W-1:0]     minor,
    output tvg_pkg::ctl_t                      ctl_out,
    output logic signed [17:0]                 vx,
    output logic signed [17:0]                 vy,
    output logic signed [16:0]                 vz
);
    import tvg_pkg::*;

    localparam logic signed [CW-1:0] ONE_C = 33'sd1073741824;

    function automatic logic signed [TRIG_W-1:0] clamp_one(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] c;
        if (v > ONE_C)
        begin
            c = ONE_C;
        end
        else if (v < -ONE_C)
        begin
            c = -ONE_C;
        end
        else
        begin
            c = v;
        end
        return c[TRIG_W-1:0];
    endfunction

    // Adds one half, divides by 2^44 toward zero and saturates to 18 bits.
    function automatic logic signed [17:0] round_xy(input logic signed [63:0] p);
        logic signed [63:0] v;
        logic signed [19:0] q;
        logic signed [17:0] r;
        v = p + 64'sd8796093022208;
        if (v[63])
        begin
            v = v + 64'sd17592186044415;
        end
        q = v[63:44];
        if (q > 20'sd131071)
        begin
            r = 18'sd131071;
        end
        else if (q < -20'sd131072)
        begin
            r = -18'sd131072;
        end
        else
        begin
            r = q[17:0];
        end
        return r;
    endfunction

    function automatic logic signed [16:0] round_z(input logic signed [47:0] p);
        logic signed [47:0] v;
        logic signed [17:0] q;
        logic signed [16:0] r;
        v = p + 48'sd536870912;
        if (v[47])
        begin
            v = v + 48'sd1073741823;
        end
        q = v[47:30];
        if (q > 18'sd65535)
        begin
            r = 17'sd65535;
        end
        else if (q < -18'sd65536)
        begin
            r = -17'sd65536;
        end
        else
        begin
            r = q[16:0];
        end
        return r;
    endfunction

    logic signed [TRIG_W-1:0] xa_c, ya_c, xb_c, yb_c;
    logic signed [TRIG_W-1:0] ca_next, sa_next, cb_next, sb_next;
    logic signed [47:0]       rho;
    logic signed [47:0]       rho_rnd;

    ctl_t                     ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg, ctl5_reg;
    logic signed [TRIG_W-1:0] ca1_reg, sa1_reg, cb1_reg, sb1_reg;
    logic signed [TRIG_W-1:0] ca2_reg, sa2_reg;
    logic signed [47:0]       pr2_reg, pz2_reg;
    logic signed [TRIG_W-1:0] ca3_reg, sa3_reg;
    logic signed [31:0]       rho3_reg;
    logic signed [16:0]       z3_reg, z4_reg, z5_reg;
    logic signed [63:0]       px4_reg, py4_reg;
    logic signed [17:0]       x5_reg, y5_reg;

    always_comb
    begin
        xa_c = clamp_one(xa);
        ya_c = clamp_one(ya);
        xb_c = clamp_one(xb);
        yb_c = clamp_one(yb);
        case (quad_a)
            2'd0:
            begin
                ca_next = xa_c;
                sa_next = ya_c;
            end
            2'd1:
            begin
                ca_next = -ya_c;
                sa_next = xa_c;
            end
            2'd2:
            begin
                ca_next = -xa_c;
                sa_next = -ya_c;
            end
            default:
            begin
                ca_next = ya_c;
                sa_next = -xa_c;
            end
        endcase
        case (quad_b)
            2'd0:
            begin
                cb_next = xb_c;
                sb_next = yb_c;
            end
            2'd1:
            begin
                cb_next = -yb_c;
                sb_next = xb_c;
            end
            2'd2:
            begin
                cb_next = -xb_c;
                sb_next = -yb_c;
            end
            default:
            begin
                cb_next = yb_c;
                sb_next = -xb_c;
            end
        endcase
        rho     = $signed({2'b00, major, 30'd0}) + pr2_reg;
        rho_rnd = rho + 48'sd32768;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
            ctl5_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
            ctl5_reg <= ctl4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ca1_reg  <= ca_next;
            sa1_reg  <= sa_next;
            cb1_reg  <= cb_next;
            sb1_reg  <= sb_next;

            ca2_reg  <= ca1_reg;
            sa2_reg  <= sa1_reg;
            pr2_reg  <= $signed({1'b0, minor}) * cb1_reg;
            pz2_reg  <= $signed({1'b0, minor}) * sb1_reg;

            ca3_reg  <= ca2_reg;
            sa3_reg  <= sa2_reg;
            rho3_reg <= rho_rnd[47:16];
            z3_reg   <= round_z(pz2_reg);

            px4_reg  <= rho3_reg * ca3_reg;
            py4_reg  <= rho3_reg * sa3_reg;
            z4_reg   <= z3_reg;

            x5_reg   <= round_xy(px4_reg);
            y5_reg   <= round_xy(py4_reg);
            z5_reg   <= z4_reg;
        end
    end

    assign ctl_out = ctl5_reg;
    assign vx      = x5_reg;
    assign vy      = y5_reg;
    assign vz      = z5_reg;

endmodule

`default_nettype wire

[rtl/core/torus_vertex_generator.sv]
// Top level of the torus vertex generator: configuration, divider chain, CORDIC chain, output.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Beat contents                              Handshake
// input     in         ring_index, tube_index                     in_valid / in_stall
// output    out        coord_x, coord_y, coord_z, index_error     out_valid / out_stall
// config    in         cfg_index, cfg_data                        cfg_we, no wait
//
// One beat is taken every cycle while in_stall is low; each beat yields one result beat
// after passing ANGLE_BITS + 11 divider cells, 30 CORDIC cells and 5 output stages.
// Reset clears the valid bits of every cell and loads the default radii and
// segment counts. While a result waits on out_stall the whole chain holds, so
// in_stall follows a stalled, valid output beat.

module torus_vertex_generator #(
    parameter int MAX_SEGMENTS = 1024,
    parameter int ANGLE_BITS   = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [tvg_pkg::IDX_W-1:0]  ring_index,
    input  wire logic [tvg_pkg::IDX_W-1:0]  tube_index,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic signed [17:0]              coord_x,
    output logic signed [17:0]              coord_y,
    output logic signed [16:0]              coord_z,
    output logic                            index_error,
    input  wire logic                       cfg_we,
    input  wire logic [1:0]                 cfg_index,
    input  wire logic [tvg_pkg::RAD_W-1:0]  cfg_data
);
    import tvg_pkg::*;

    // Width of the phase numerator index * 2^ANGLE_BITS + seg/2.
    localparam int NUM_W = IDX_W + ANGLE_BITS + 1;
    // Segment counts above the cap are treated as the cap; an 11-bit count
    // never exceeds 2047, so larger caps change nothing.
    localparam int              SegCap  = (MAX_SEGMENTS > 2047) ? 2047 : MAX_SEGMENTS;
    localparam logic [SEG_W-1:0] SEG_CAP = SEG_W'(SegCap);

    logic [RAD_W-1:0] major_reg;
    logic [RAD_W-1:0] minor_reg;
    logic [SEG_W-1:0] ring_seg_reg;
    logic [SEG_W-1:0] tube_seg_reg;

    logic             en;
    logic [SEG_W-1:0] rs_eff;
    logic [SEG_W-1:0] ts_eff;
    ctl_t             ctl_in;

    // Configuration registers. Writes must arrive only while the chain is empty; the
    // block itself does not enforce this. Every cell reads them directly.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            major_reg    <= 16'd15360;
            minor_reg    <= 16'd5120;
            ring_seg_reg <= 11'd12;
            tube_seg_reg <= 11'd12;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAJOR: major_reg    <= cfg_data;
                REG_MINOR: minor_reg    <= cfg_data;
                REG_RING:  ring_seg_reg <= cfg_data[SEG_W-1:0];
                REG_TUBE:  tube_seg_reg <= cfg_data[SEG_W-1:0];
                default:   ;
            endcase
        end
    end

    assign rs_eff = (ring_seg_reg > SEG_CAP) ? SEG_CAP : ring_seg_reg;
    assign ts_eff = (tube_seg_reg > SEG_CAP) ? SEG_CAP : tube_seg_reg;

    // The whole chain moves together; it holds only while a finished result
    // is refused downstream.
    assign in_stall = out_valid & out_stall;
    assign en       = ~in_stall;

    assign ctl_in.valid = in_valid;
    assign ctl_in.err   = ({1'b0, ring_index} >= rs_eff) || ({1'b0, tube_index} >= ts_eff);

    // Divider chain: one quotient bit per cell, most significant first.
    ctl_t                  dctl  [NUM_W+1];
    logic [NUM_W-1:0]      dnum_a[NUM_W+1];
    logic [NUM_W-1:0]      dnum_b[NUM_W+1];
    logic [SEG_W-1:0]      drem_a[NUM_W+1];
    logic [SEG_W-1:0]      drem_b[NUM_W+1];
    logic [ANGLE_BITS-1:0] dq_a  [NUM_W+1];
    logic [ANGLE_BITS-1:0] dq_b  [NUM_W+1];

    assign dctl[0]   = ctl_in;
    assign dnum_a[0] = NUM_W'({ring_index, {ANGLE_BITS{1'b0}}}) + NUM_W'(rs_eff[SEG_W-1:1]);
    assign dnum_b[0] = NUM_W'({tube_index, {ANGLE_BITS{1'b0}}}) + NUM_W'(ts_eff[SEG_W-1:1]);
    assign drem_a[0] = '0;
    assign drem_b[0] = '0;
    assign dq_a[0]   = '0;
    assign dq_b[0]   = '0;

    for (genvar i = 0; i < NUM_W; i++)
    begin : g_div
        tvg_div_cell #(
            .NUM_W (NUM_W),
            .Q_W   (ANGLE_BITS),
            .BIT   (NUM_W - 1 - i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .ctl_in    (dctl[i]),
            .seg_a     (rs_eff),
            .seg_b     (ts_eff),
            .num_a_in  (dnum_a[i]),
            .num_b_in  (dnum_b[i]),
            .rem_a_in  (drem_a[i]),
            .rem_b_in  (drem_b[i]),
            .q_a_in    (dq_a[i]),
            .q_b_in    (dq_b[i]),
            .ctl_out   (dctl[i+1]),
            .num_a_out (dnum_a[i+1]),
            .num_b_out (dnum_b[i+1]),
            .rem_a_out (drem_a[i+1]),
            .rem_b_out (drem_b[i+1]),
            .q_a_out   (dq_a[i+1]),
            .q_b_out   (dq_b[i+1])
        );
    end

    // A zero segment count gives a zero phase. The phase is the quotient
    // modulo one turn, placed at the top of a 32-bit word.
    logic [PHASE_W-1:0] phase_a;
    logic [PHASE_W-1:0] phase_b;

    assign phase_a = (rs_eff == '0) ? '0 : {dq_a[NUM_W], {(PHASE_W-ANGLE_BITS){1'b0}}};
    assign phase_b = (ts_eff == '0) ? '0 : {dq_b[NUM_W], {(PHASE_W-ANGLE_BITS){1'b0}}};

    // CORDIC chain: the top two phase bits pick the quadrant, the rest is
    // rotated out one step per cell.
    ctl_t              cctl [CORDIC_STEPS+1];
    logic [1:0]        cqa  [CORDIC_STEPS+1];
    logic [1:0]        cqb  [CORDIC_STEPS+1];
    logic signed [CW-1:0] cxa[CORDIC_STEPS+1];
    logic signed [CW-1:0] cya[CORDIC_STEPS+1];
    logic signed [CW-1:0] cza[CORDIC_STEPS+1];
    logic signed [CW-1:0] cxb[CORDIC_STEPS+1];
    logic signed [CW-1:0] cyb[CORDIC_STEPS+1];
    logic signed [CW-1:0] czb[CORDIC_STEPS+1];

    assign cctl[0] = dctl[NUM_W];
    assign cqa[0]  = phase_a[PHASE_W-1:PHASE_W-2];
    assign cqb[0]  = phase_b[PHASE_W-1:PHASE_W-2];
    assign cxa[0]  = CORDIC_GAIN;
    assign cya[0]  = '0;
    assign cza[0]  = $signed({3'b000, phase_a[PHASE_W-3:0]});
    assign cxb[0]  = CORDIC_GAIN;
    assign cyb[0]  = '0;
    assign czb[0]  = $signed({3'b000, phase_b[PHASE_W-3:0]});

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_cordic
        tvg_cordic_cell #(
            .STEP (k)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .ctl_in     (cctl[k]),
            .quad_a_in  (cqa[k]),
            .quad_b_in  (cqb[k]),
            .xa_in      (cxa[k]),
            .ya_in      (cya[k]),
            .za_in      (cza[k]),
            .xb_in      (cxb[k]),
            .yb_in      (cyb[k]),
            .zb_in      (czb[k]),
            .ctl_out    (cctl[k+1]),
            .quad_a_out (cqa[k+1]),
            .quad_b_out (cqb[k+1]),
            .xa_out     (cxa[k+1]),
            .ya_out     (cya[k+1]),
            .za_out     (cza[k+1]),
            .xb_out     (cxb[k+1]),
            .yb_out     (cyb[k+1]),
            .zb_out     (czb[k+1])
        );
    end

    // Radius scaling and rounding; its last stage is the output register.
    ctl_t out_ctl;

    tvg_mix u_mix (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (cctl[CORDIC_STEPS]),
        .quad_a  (cqa[CORDIC_STEPS]),
        .quad_b  (cqb[CORDIC_STEPS]),
        .xa      (cxa[CORDIC_STEPS]),
        .ya      (cya[CORDIC_STEPS]),
        .xb      (cxb[CORDIC_STEPS]),
        .yb      (cyb[CORDIC_STEPS]),
        .major   (major_reg),
        .minor   (minor_reg),
        .ctl_out (out_ctl),
        .vx      (coord_x),
        .vy      (coord_y),
        .vz      (coord_z)
    );

    assign out_valid   = out_ctl.valid;
    assign index_error = out_ctl.err;

    // A vertex never lies farther from the axis plane than the tube radius,
    // nor farther from the axis than the sum of both radii.
    logic [RAD_W:0] rad_sum;
    assign rad_sum = {1'b0, major_reg} + {1'b0, minor_reg};

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(coord_z) <= $signed({2'b00, minor_reg}))
                   && ($signed(coord_z) >= -$signed({2'b00, minor_reg})))
        else $error("coord_z beyond the tube radius");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(coord_x) <= $signed({2'b00, rad_sum}))
                   && ($signed(coord_x) >= -$signed({2'b00, rad_sum})))
        else $error("coord_x beyond the outer radius");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(coord_y) <= $signed({2'b00, rad_sum}))
                   && ($signed(coord_y) >= -$signed({2'b00, rad_sum})))
        else $error("coord_y beyond the outer radius");

endmodule

`default_nettype wire

[tb/torus_vertex_checker.sv]
// Checker for the torus vertex generator: predicts each vertex and compares result beats.
`timescale 1ns / 1ps

module torus_vertex_checker (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    input  wire logic                      in_stall,
    input  wire logic [tvg_pkg::IDX_W-1:0] ring_index,
    input  wire logic [tvg_pkg::IDX_W-1:0] tube_index,
    input  wire logic                      out_valid,
    input  wire logic                      out_stall,
    input  wire logic signed [17:0]        coord_x,
    input  wire logic signed [17:0]        coord_y,
    input  wire logic signed [16:0]        coord_z,
    input  wire logic                      index_error,
    input  wire logic                      cfg_we,
    input  wire logic [1:0]                cfg_index,
    input  wire logic [tvg_pkg::RAD_W-1:0] cfg_data,
    output int                             failures,
    output int                             pending,
    output int                             checked
);
    import tvg_pkg::*;

    localparam int  SEG_LIMIT  = 1024;
    localparam int  PHASE_BITS = 16;
    localparam longint ONE_Q30 = 64'sd1 << 30;

    typedef struct packed {
        logic signed [17:0] x;
        logic signed [17:0] y;
        logic signed [16:0] z;
        logic               err;
    } vertex_t;

    // Rotation per CORDIC step, in units of 2^-32 turn.
    localparam longint ROT_STEP [30] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
        64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
        64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051, 64'h00000028,
        64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000002, 64'h00000001
    };

    logic [15:0] r_major, r_minor;
    logic [10:0] r_ring, r_tube;
    vertex_t     vertex_q [$];

    function automatic logic [31:0] turn_fraction(input longint idx, input longint seg);
        longint p;
        if (seg == 0)
            return 32'd0;
        p = ((idx << PHASE_BITS) + seg / 2) / seg;
        p = p & ((64'sd1 << PHASE_BITS) - 1);
        return 32'(p << (32 - PHASE_BITS));
    endfunction

    function automatic void rotate(input logic [31:0] t, output longint c, output longint s);
        longint x, y, z, nx;
        x = 64'sd652032874;
        y = 0;
        z = longint'(t[29:0]);
        for (int i = 0; i < 30; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - ROT_STEP[i];
            end
            else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + ROT_STEP[i];
            end
            x = nx;
        end
        x = (x < -ONE_Q30) ? -ONE_Q30 : ((x > ONE_Q30) ? ONE_Q30 : x);
        y = (y < -ONE_Q30) ? -ONE_Q30 : ((y > ONE_Q30) ? ONE_Q30 : y);
        case (t[31:30])
            2'd0:    begin c = x;  s = y;  end
            2'd1:    begin c = -y; s = x;  end
            2'd2:    begin c = -x; s = -y; end
            default: begin c = y;  s = -x; end
        endcase
    endfunction

    function automatic longint trunc_shift(input longint v, input int sh);
        return (v < 0) ? -((-v) >>> sh) : (v >>> sh);
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic vertex_t torus_point(input logic [9:0] ri, input logic [9:0] ti);
        longint  rs, ts, ca, sa, cb, sb, rho, rho14;
        vertex_t v;
        rs = (r_ring > SEG_LIMIT) ? SEG_LIMIT : r_ring;
        ts = (r_tube > SEG_LIMIT) ? SEG_LIMIT : r_tube;
        rotate(turn_fraction(ri, rs), ca, sa);
        rotate(turn_fraction(ti, ts), cb, sb);
        rho   = longint'(r_major) * ONE_Q30 + longint'(r_minor) * cb;
        rho14 = (rho + (64'sd1 << 15)) >>> 16;
        v.x   = 18'(clip(trunc_shift(rho14 * ca + (64'sd1 << 43), 44), -131072, 131071));
        v.y   = 18'(clip(trunc_shift(rho14 * sa + (64'sd1 << 43), 44), -131072, 131071));
        v.z   = 17'(clip(trunc_shift(longint'(r_minor) * sb + (64'sd1 << 29), 30),
                         -65536, 65535));
        v.err = (ri >= rs) || (ti >= ts);
        return v;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        failures++;
    endtask

    assign pending = vertex_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        vertex_t want;
        if (!rst_n) begin
            r_major <= 16'd15360;
            r_minor <= 16'd5120;
            r_ring  <= 11'd12;
            r_tube  <= 11'd12;
            vertex_q.delete();
        end
        else begin
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    REG_MAJOR: r_major <= cfg_data;
                    REG_MINOR: r_minor <= cfg_data;
                    REG_RING:  r_ring  <= cfg_data[10:0];
                    REG_TUBE:  r_tube  <= cfg_data[10:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                vertex_q.push_back(torus_point(ring_index, tube_index));
            if (out_valid && !out_stall) begin
                if (vertex_q.size() == 0) begin
                    $display("[%0t] result beat with no vertex expected", $realtime);
                    failures++;
                end
                else begin
                    want = vertex_q.pop_front();
                    checked++;
                    if (coord_x !== want.x) report("coord_x", coord_x, want.x);
                    if (coord_y !== want.y) report("coord_y", coord_y, want.y);
                    if (coord_z !== want.z) report("coord_z", coord_z, want.z);
                    if (index_error !== want.err) report("index_error", index_error, want.err);
                end
            end
        end
    end

    initial begin
        failures = 0;
        checked  = 0;
    end

endmodule

[tb/tb_torus_vertex_generator.sv]
// Stimulus and verdict for the torus vertex generator.
`timescale 1ns / 1ps

module tb_torus_vertex_generator;
    import tvg_pkg::*;

    // Generous bound on the whole run, well above the slowest legal run.
    localparam int CYCLE_LIMIT = 600000;
    // The pipeline is 62 stages deep; DRAIN is larger than that depth.
    localparam int DRAIN       = 100;
    localparam int PER_PHASE   = 210;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic [IDX_W-1:0] ring_index = '0;
    logic [IDX_W-1:0] tube_index = '0;
    logic out_stall = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [RAD_W-1:0] cfg_data = '0;

    wire logic in_stall, out_valid, index_error;
    wire logic signed [17:0] coord_x, coord_y;
    wire logic signed [16:0] coord_z;

    int failures, pending, checked;
    int beats_sent = 0;
    int cycles = 0;
    bit hold_long = 1'b0;
    bit calm = 1'b0;       // when set, both sides run without idle gaps
    int seg_now = 12;      // ring segment count of the current phase
    int tseg_now = 12;

    torus_vertex_generator DUT (
        .clk, .rst_n, .in_valid, .in_stall, .ring_index, .tube_index,
        .out_valid, .out_stall, .coord_x, .coord_y, .coord_z, .index_error,
        .cfg_we, .cfg_index, .cfg_data
    );

    torus_vertex_checker u_checker (
        .clk, .rst_n, .in_valid, .in_stall, .ring_index, .tube_index,
        .out_valid, .out_stall, .coord_x, .coord_y, .coord_z, .index_error,
        .cfg_we, .cfg_index, .cfg_data, .failures, .pending, .checked
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Idle gap drawn per beat; calm stretches force back-to-back traffic.
    function automatic int idle_gap();
        if (calm)
            return 0;
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    endfunction

    // Mostly in-range indexes for the segment count, sometimes any 10-bit value.
    function automatic logic [9:0] pick_index(input int seg);
        int lim;
        lim = (seg > 1024) ? 1024 : seg;
        if (lim > 0 && $urandom_range(0, 99) < 80)
            return 10'($urandom_range(0, lim - 1));
        return 10'($urandom_range(0, 1023));
    endfunction

    // Offer one input beat and hold it until the block takes it.
    task automatic send_beat(input logic [9:0] ri, input logic [9:0] ti);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        ring_index <= ri;
        tube_index <= ti;
        do @(posedge clk); while (in_stall);
        beats_sent++;
    endtask

    // Register writes happen only with the pipeline empty and settled.
    task automatic load_shape(input logic [15:0] major, input logic [15:0] minor,
                              input logic [15:0] rings, input logic [15:0] tubes);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MAJOR;
        cfg_data  <= major;
        @(posedge clk);
        cfg_index <= REG_MINOR;
        cfg_data  <= minor;
        @(posedge clk);
        cfg_index <= REG_RING;
        cfg_data  <= rings;
        @(posedge clk);
        cfg_index <= REG_TUBE;
        cfg_data  <= tubes;
        @(posedge clk);
        cfg_we   <= 1'b0;
        seg_now  = rings[10:0];
        tseg_now = tubes[10:0];
    endtask

    task automatic random_phase(input int count);
        for (int n = 0; n < count; n++) begin
            if (n % 60 == 0)
                calm = ($urandom_range(0, 3) == 0);
            send_beat(pick_index(seg_now), pick_index(tseg_now));
        end
        calm = 1'b0;
    endtask

    // Receiver: draws a stall per result beat, and honors the long hold-off.
    initial begin
        int n;
        @(posedge rst_n);
        forever begin
            n = idle_gap();
            if (n > 0 || hold_long) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                while (hold_long) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Back-pressure episode: the output is blocked long enough that the
    // pipeline fills and the input side must stall while beats keep coming.
    initial begin
        wait (beats_sent >= 700);
        hold_long = 1'b1;
        repeat (400) @(posedge clk);
        hold_long = 1'b0;
    end

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats at the reset shape: corners, quadrants, bad indexes.
        send_beat(10'd0, 10'd0);
        send_beat(10'd3, 10'd0);
        send_beat(10'd6, 10'd0);
        send_beat(10'd9, 10'd0);
        send_beat(10'd0, 10'd3);
        send_beat(10'd0, 10'd6);
        send_beat(10'd0, 10'd9);
        send_beat(10'd11, 10'd11);
        send_beat(10'd12, 10'd0);
        send_beat(10'd0, 10'd12);
        send_beat(10'd1023, 10'd1023);
        send_beat(10'd1023, 10'd0);
        send_beat(10'd0, 10'd1023);
        send_beat(10'h2AA, 10'h155);
        send_beat(10'h155, 10'h2AA);
        send_beat(10'd5, 10'd7);
        random_phase(PER_PHASE);

        // Degenerate torus: zero radii, a single segment each way.
        load_shape(16'd0, 16'd0, 16'd1, 16'd1);
        send_beat(10'd0, 10'd0);
        send_beat(10'd1, 10'd1);
        random_phase(60);

        // Largest radii and the maximum segment count.
        load_shape(16'hFFFF, 16'hFFFF, 16'd1024, 16'd1024);
        send_beat(10'd0, 10'd512);
        send_beat(10'd256, 10'd768);
        send_beat(10'd1023, 10'd1023);
        random_phase(PER_PHASE);

        // Zero ring count flags every beat; counts above the maximum saturate.
        load_shape(16'd30000, 16'hFFFF, 16'd0, 16'd7);
        random_phase(150);
        load_shape(16'd256, 16'd40000, 16'd2047, 16'd1500);
        random_phase(PER_PHASE);
        load_shape(16'hFFFF, 16'd0, 16'd3, 16'd0);
        random_phase(150);

        // Random shapes, first with ordinary segment counts, then with any count up to 2047.
        for (int p = 0; p < 3; p++) begin
            load_shape(16'($urandom), 16'($urandom),
                       16'($urandom_range(1, 64)), 16'($urandom_range(1, 64)));
            random_phase(PER_PHASE);
        end
        load_shape(16'($urandom), 16'($urandom), 16'($urandom_range(1, 2047)),
                   16'($urandom_range(1, 2047)));
        random_phase(PER_PHASE - 100);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("Sent %0d index pairs over ten torus shapes, %0d vertices compared.",
                 beats_sent, checked);
        $display("Shapes covered zero and full-scale radii and segment counts 0 to 2047.");
        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
